/* hdl/qnh_pkg.sv */
`default_nettype none
package qnh_pkg;

    localparam int TABLE_INDEX_BITS_DEF = 6;
    localparam logic signed [63:0] A_Q24  = 64'sd3192087;
    localparam logic signed [63:0] B_Q24  = 64'sd88178991;
    localparam logic signed [63:0] LT_Q40 = 64'sd24802410;
    localparam logic [16:0] P0_PA   = 17'd101325;
    localparam logic [17:0] QNH_MAX = 18'd262143;

    // 2^(2^-j) in Q30, j = 1..10
    function automatic logic [63:0] root_chain(input int j);
        logic [63:0] r;
        begin
            case (j)
                1: r = 64'd1518500250;
                2: r = 64'd1276901417;
                3: r = 64'd1170923762;
                4: r = 64'd1121280436;
                5: r = 64'd1097253708;
                6: r = 64'd1085434106;
                7: r = 64'd1079572136;
                8: r = 64'd1076653033;
                9: r = 64'd1075196443;
                default: r = 64'd1074468888;
            endcase
            return r;
        end
    endfunction

    // log rom entry: log2(1+i/2^k) in q24
    function automatic logic signed [31:0] rom_log(input int k, input int i);
        logic [63:0] y;
        logic [31:0] r;
        begin
            y = (64'd1 << 30) + (64'(i) << (30 - k));
            r = '0;
            if (y >= (64'd2 << 30))
            begin
                r = 32'd1 << 24;
            end
            else
            begin
                for (int b = 23; b >= 0; b--)
                begin
                    y = (y * y) >> 30;
                    if (y >= (64'd2 << 30))
                    begin
                        r[b] = 1'b1;
                        y = y >> 1;
                    end
                end
            end
            return signed'(r);
        end
    endfunction

    // exp rom entry: 2^(i/2^k) in q24
    function automatic logic [31:0] rom_exp(input int k, input int i);
        logic [63:0] prod;
        begin
            prod = 64'd1 << 30;
            if (i >= (1 << k))
            begin
                prod = 64'd1 << 31;
            end
            else
            begin
                for (int j = 1; j <= k; j++)
                begin
                    if (((i >> (k - j)) & 1) != 0)
                    begin
                        prod = (prod * root_chain(j)) >> 30;
                    end
                end
            end
            return 32'((prod + 64'd32) >> 6);
        end
    endfunction

    // floor shift right
    function automatic logic signed [63:0] sra64(input logic signed [63:0] v, input int s);
        begin
            return v >>> s;
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/qnh_log2.sv */
`default_nettype none
// two-stage log2 in q24: leading-one search and table read, then interpolation
module qnh_log2 #(
    parameter int TABLE_INDEX_BITS = qnh_pkg::TABLE_INDEX_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic        [39:0] v,
    output logic signed [31:0]      lg
);
    import qnh_pkg::*;

    localparam int K = TABLE_INDEX_BITS;
    localparam int REM_BITS = 24 - K;
    localparam int N = (1 << K) + 1;

    logic signed [31:0] log_tab [N];
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            log_tab[i] = rom_log(K, i);
        end
    end

    logic [5:0] e;
    logic [23:0] f;
    logic [63:0] sh;
    logic [K:0] idx;
    always_comb
    begin
        e = '0;
        for (int i = 1; i < 40; i++)
        begin
            if (v[i])
            begin
                e = 6'(i);
            end
        end
        sh = ({24'd0, v} << 24) >> e;
        f = sh[23:0];
        idx = {1'b0, f[23:REM_BITS]};
    end

    logic [5:0] e_reg;
    logic signed [31:0] lo_reg;
    logic signed [31:0] dlt_reg;
    logic [REM_BITS-1:0] rem_reg;
    always_ff @(posedge clk)
    begin
        e_reg   <= e;
        lo_reg  <= log_tab[idx];
        dlt_reg <= log_tab[idx + 1'b1] - log_tab[idx];
        rem_reg <= f[REM_BITS-1:0];
    end

    logic signed [63:0] prod;
    always_comb
    begin
        prod = 64'(dlt_reg) * signed'({1'b0, rem_reg});
    end

    always_ff @(posedge clk)
    begin
        lg <= 32'({e_reg, 24'd0}) + lo_reg + 32'(prod >>> REM_BITS);
    end
endmodule
`default_nettype wire

/* hdl/qnh_exp2.sv */
`default_nettype none
// two-stage exp2: table read, then interpolation; mantissa q24 in [1,2], exponent k
module qnh_exp2 #(
    parameter int TABLE_INDEX_BITS = qnh_pkg::TABLE_INDEX_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic signed [39:0] t,
    output logic             [25:0] mant,
    output logic signed      [15:0] k
);
    import qnh_pkg::*;

    localparam int K = TABLE_INDEX_BITS;
    localparam int REM_BITS = 24 - K;
    localparam int N = (1 << K) + 1;

    logic [31:0] exp_tab [N];
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            exp_tab[i] = rom_exp(K, i);
        end
    end

    logic [23:0] f;
    logic [K:0] idx;
    assign f = t[23:0];
    assign idx = {1'b0, f[23:REM_BITS]};

    logic signed [15:0] k_reg;
    logic [31:0] lo_reg;
    logic [31:0] dlt_reg;
    logic [REM_BITS-1:0] rem_reg;
    always_ff @(posedge clk)
    begin
        k_reg   <= 16'(t >>> 24);
        lo_reg  <= exp_tab[idx];
        dlt_reg <= exp_tab[idx + 1'b1] - exp_tab[idx];
        rem_reg <= f[REM_BITS-1:0];
    end

    logic [63:0] prod;
    assign prod = 64'(dlt_reg) * 64'(rem_reg);

    always_ff @(posedge clk)
    begin
        k    <= k_reg;
        mant <= 26'(lo_reg + 32'(prod >> REM_BITS));
    end
endmodule
`default_nettype wire

/* hdl/qnh_sea_level_pressure.sv */
`default_nettype none
// channel  | ports                                            | handshake
// input    | pressure_pa pressure_ok elevation_m elevation_ok | start && !busy
// result   | qnh_pa qnh_ok clipped                            | done, one cycle
//
// a pipeline of registered stages from start to done; one transaction per cycle
// depth is set by the two log2 units, two exp2 units, three multiplies, the final scaling and the output registers
// busy is always low: the pipeline never stalls, the receiver cannot hold off
// rst_n clears only the valid bits; payload stages are not reset
module qnh_sea_level_pressure #(
    parameter int TABLE_INDEX_BITS = qnh_pkg::TABLE_INDEX_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [16:0] pressure_pa,
    input  wire logic        pressure_ok,
    input  wire logic [14:0] elevation_m,
    input  wire logic        elevation_ok,
    output logic             done,
    output logic      [17:0] qnh_pa,
    output logic             qnh_ok,
    output logic             clipped
);
    import qnh_pkg::*;

    localparam int LAT = 14;

    // log2(p0) is a constant, taken from the same table arithmetic
    localparam int K = TABLE_INDEX_BITS;
    localparam int RB = 24 - K;
    localparam int P0F = (101325 << 8) - (1 << 24);
    localparam logic signed [31:0] LOG2P0 = 32'(16 << 24) + rom_log(K, P0F >> RB)
        + 32'((64'(rom_log(K, (P0F >> RB) + 1) - rom_log(K, P0F >> RB))
        * 64'(P0F & ((1 << RB) - 1))) >>> RB);

    // side band: bypass kind and elevation travel with the data
    typedef struct packed {
        logic        ok;
        logic        zero;
        logic signed [14:0] elev;
    } side_t;

    logic  vld_reg [LAT];
    side_t side_reg [LAT];
    side_t side_next;

    always_comb
    begin
        side_next.ok   = pressure_ok & elevation_ok;
        side_next.zero = (pressure_pa == '0);
        side_next.elev = signed'(elevation_m);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= start & ~busy;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int i = 1; i < LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // stages 1-2: log2 of pressure (zero pressure forced to 1, result unused)
    logic signed [31:0] lgp;
    qnh_log2 #(.TABLE_INDEX_BITS(TABLE_INDEX_BITS)) u_logp (
        .clk (clk),
        .v   ({23'd0, (pressure_pa == '0) ? 17'd1 : pressure_pa}),
        .lg  (lgp)
    );

    // stage 3: t = (log2 p - log2 p0) * a
    logic signed [39:0] t_reg;
    logic signed [63:0] t_prod;
    assign t_prod = 64'(lgp - LOG2P0) * A_Q24;
    always_ff @(posedge clk)
    begin
        t_reg <= 40'(t_prod >>> 24);
    end

    // stages 4-5: 2^t
    logic [25:0] m1;
    logic signed [15:0] k1;
    qnh_exp2 #(.TABLE_INDEX_BITS(TABLE_INDEX_BITS)) u_exp1 (
        .clk  (clk),
        .t    (t_reg),
        .mant (m1),
        .k    (k1)
    );

    // stage 6: scale to q24 and add elevation term, base in q24
    logic signed [47:0] y1;
    logic signed [47:0] lterm;
    logic signed [47:0] base_reg;
    always_comb
    begin
        if (k1 >= 0)
        begin
            y1 = (k1 > 20) ? (48'sd1 <<< 45) : signed'(48'(m1) << k1[4:0]);
        end
        else if (k1 < -40)
        begin
            y1 = '0;
        end
        else
        begin
            y1 = signed'((48'(m1) + (48'd1 << (6'(-k1) - 6'd1))) >> 6'(-k1));
        end
        lterm = 48'((64'(side_reg[4].elev) * LT_Q40) >>> 16);
    end
    always_ff @(posedge clk)
    begin
        base_reg <= y1 + lterm;
    end

    // stages 7-8: log2 of base; nonpositive base flagged by its own delay chain
    logic nonpos_reg [2];
    always_ff @(posedge clk)
    begin
        nonpos_reg[0] <= (base_reg <= 0);
        nonpos_reg[1] <= nonpos_reg[0];
    end

    logic signed [31:0] lgb;
    qnh_log2 #(.TABLE_INDEX_BITS(TABLE_INDEX_BITS)) u_logb (
        .clk (clk),
        .v   ((base_reg <= 0) ? 40'd1 : base_reg[39:0]),
        .lg  (lgb)
    );

    // stage 9: u = (log2 base - 24) * b + log2 p0
    logic signed [39:0] u_reg;
    logic signed [63:0] u_prod;
    assign u_prod = 64'(lgb - (32'sd24 <<< 24)) * B_Q24;
    logic nonpos9_reg;
    always_ff @(posedge clk)
    begin
        u_reg <= 40'(u_prod >>> 24) + 40'(LOG2P0);
        nonpos9_reg <= nonpos_reg[1];
    end

    // stages 10-11: 2^u
    logic [25:0] m2;
    logic signed [15:0] k2;
    qnh_exp2 #(.TABLE_INDEX_BITS(TABLE_INDEX_BITS)) u_exp2 (
        .clk  (clk),
        .t    (u_reg),
        .mant (m2),
        .k    (k2)
    );
    logic np10_reg;
    logic np11_reg;
    always_ff @(posedge clk)
    begin
        np10_reg <= nonpos9_reg;
        np11_reg <= np10_reg;
    end

    // stage 12: scale to pascals, round half up
    logic [47:0] r12;
    logic signed [15:0] s12;
    always_comb
    begin
        s12 = k2 - 16'sd24;
        if (s12 >= 0)
        begin
            r12 = (s12 > 20) ? (48'd1 << 45) : (48'(m2) << s12[4:0]);
        end
        else if (s12 < -40)
        begin
            r12 = '0;
        end
        else
        begin
            r12 = (48'(m2) + (48'd1 << (6'(-s12) - 6'd1))) >> 6'(-s12);
        end
    end
    logic [47:0] r_reg;
    logic np12_reg;
    always_ff @(posedge clk)
    begin
        r_reg <= r12;
        np12_reg <= np11_reg;
    end

    // stages 13-14: special cases and output register
    logic [17:0] q_next;
    logic ok_next;
    logic clip_next;
    always_comb
    begin
        q_next = '0;
        ok_next = 1'b0;
        clip_next = 1'b0;
        if (side_reg[11].ok)
        begin
            if (side_reg[11].zero)
            begin
                ok_next = 1'b1;
            end
            else if (!np12_reg)
            begin
                ok_next = 1'b1;
                if (r_reg > 48'(QNH_MAX))
                begin
                    q_next = QNH_MAX;
                    clip_next = 1'b1;
                end
                else
                begin
                    q_next = r_reg[17:0];
                end
            end
        end
    end

    logic [17:0] q_reg [2];
    logic ok_reg [2];
    logic clip_reg [2];
    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next;
        ok_reg[0] <= ok_next;
        clip_reg[0] <= clip_next;
        q_reg[1] <= q_reg[0];
        ok_reg[1] <= ok_reg[0];
        clip_reg[1] <= clip_reg[0];
    end

    assign busy    = 1'b0;
    assign done    = vld_reg[LAT-1];
    assign qnh_pa  = q_reg[1];
    assign qnh_ok  = ok_reg[1];
    assign clipped = clip_reg[1];

    // a done strobe traces back to a start
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT)) else $error("done without start");
    // saturation implies full-scale valid output
    a_clip_max: assert property (@(posedge clk) disable iff (!rst_n)
        (done && clipped) |-> (qnh_ok && qnh_pa == QNH_MAX)) else $error("bad clip");
    // a not-valid result reads zero
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !qnh_ok) |-> (qnh_pa == '0 && !clipped)) else $error("bad invalid");

endmodule
`default_nettype wire
